[design/aclwm_pkg.sv]
// Shared constants for the ACL wildcard rule matcher.
// No dependencies.
package aclwm_pkg;

  localparam int unsigned CharWidth   = 8;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned PosWidth    = 6;

  localparam logic [CharWidth-1:0] SepCode   = 8'd58;
  localparam logic [CharWidth-1:0] AnyCode   = 8'd42;
  localparam logic [CharWidth-1:0] OwnerCode = 8'd94;

  localparam logic [StatusWidth-1:0] StRuleStored  = 3'd0;
  localparam logic [StatusWidth-1:0] StRuleEmpty   = 3'd1;
  localparam logic [StatusWidth-1:0] StTableFull   = 3'd2;
  localparam logic [StatusWidth-1:0] StRuleTooLong = 3'd3;
  localparam logic [StatusWidth-1:0] StQueryDone   = 3'd4;

endpackage

[design/aclwm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aclwm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/acl_wildcard_rule_matcher_unit.sv]
// ACL wildcard rule matcher: top level.
// Rule/query characters are taken one per cycle while in_stall_o is low; a rule's final
// character answers at once, then its segments are copied into the segment RAM in turn.
// A query walks the stored rules through the segment RAM: per rule S_RCNT reads the count,
// then S_SEG compares one segment at a time; S_RES responds once the output is free.
// Reset (async, active low) empties the table; RAM contents are never cleared.
module acl_wildcard_rule_matcher_unit #(
  parameter int unsigned MAX_RULES     = 64,
  parameter int unsigned MAX_SEGMENTS  = 8,
  parameter int unsigned SEGMENT_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  req_type_i,
  input  logic [aclwm_pkg::CharWidth-1:0]       char_code_i,
  input  logic                                  last_char_i,
  input  logic                                  rule_allows_i,
  input  logic [31:0]                           user_id_i,
  input  logic [31:0]                           owner_id_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [aclwm_pkg::StatusWidth-1:0]     status_o,
  output logic                                  access_granted_o,
  output logic                                  rule_matched_o,
  output logic [aclwm_pkg::PosWidth-1:0]        match_position_o
);

  localparam int unsigned RW = $clog2(MAX_RULES);
  localparam int unsigned SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned IW = $clog2(MAX_SEGMENTS + 2);
  localparam logic [RW:0] MaxR = (RW + 1)'(MAX_RULES);
  localparam logic [IW-1:0] MaxSeg = IW'(MAX_SEGMENTS);
  localparam logic [IW-1:0] TooMany = IW'(MAX_SEGMENTS + 1);
  localparam logic [SEGMENT_WIDTH-1:0] AnyV = SEGMENT_WIDTH'(aclwm_pkg::AnyCode);
  localparam logic [SEGMENT_WIDTH-1:0] OwnerV = SEGMENT_WIDTH'(aclwm_pkg::OwnerCode);
  localparam logic [aclwm_pkg::CharWidth-1:0] SpaceCode = 8'd32;
  localparam logic [aclwm_pkg::CharWidth-1:0] TabCode = 8'd9;
  localparam logic [aclwm_pkg::CharWidth-1:0] CrCode = 8'd13;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_RCNT  = 3'd2;
  localparam logic [2:0] S_SEG   = 3'd3;
  localparam logic [2:0] S_RES   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [SEGMENT_WIDTH-1:0] sum_q, sum_d;
  logic [IW-1:0] idx_q, idx_d;
  logic seen_q, seen_d;
  logic [SEGMENT_WIDTH-1:0] build_q [MAX_SEGMENTS];
  logic [RW:0] allow_cnt_q, allow_cnt_d, deny_cnt_q, deny_cnt_d;
  logic [IW-1:0] qcnt_q, qcnt_d;
  logic eq_q, eq_d;
  logic [RW-1:0] pos_q, pos_d;
  logic [RW-1:0] slot_q, slot_d;
  logic [CW-1:0] seg_i_q, seg_i_d;
  logic res_allow_q, res_allow_d, res_hit_q, res_hit_d;

  logic out_valid_q;
  logic [aclwm_pkg::StatusWidth-1:0] status_q;
  logic grant_q, hit_q;
  logic [aclwm_pkg::PosWidth-1:0] mpos_q;

  logic in_acc, out_free, out_load;
  logic [aclwm_pkg::StatusWidth-1:0] load_status;
  logic load_grant, load_hit;
  logic [aclwm_pkg::PosWidth-1:0] load_pos;

  logic is_space, do_close, do_store;
  logic [SEGMENT_WIDTH:0] sum_add;
  logic [SEGMENT_WIDTH-1:0] sum_sat, seg_val;
  logic [IW-1:0] idx_n;
  logic seen_n;
  logic [RW:0] total;
  logic [RW:0] deny_slot;
  logic [aclwm_pkg::StatusWidth-1:0] rule_status;

  logic [RW:0] walk_slot;
  logic cnt_we, cnt_re, seg_we, seg_re;
  logic [RW-1:0] cnt_waddr, cnt_raddr;
  logic [CW:0] cnt_wdata, cnt_rdata;
  logic [RW+SW-1:0] seg_waddr, seg_raddr;
  logic [SEGMENT_WIDTH-1:0] seg_rdata;

  logic [CW-1:0] n_seg, seg_i_inc;
  logic seg_ok, seg_last;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign total = allow_cnt_q + deny_cnt_q;
  assign deny_slot = MaxR - 1'b1 - deny_cnt_q;

  // Character front end
  always_comb begin
    is_space = !req_type_i && ((char_code_i == SpaceCode) ||
               ((char_code_i >= TabCode) && (char_code_i <= CrCode)));
    sum_add = {1'b0, sum_q} + (SEGMENT_WIDTH + 1)'(char_code_i);
    sum_sat = sum_add[SEGMENT_WIDTH] ? '1 : sum_add[SEGMENT_WIDTH-1:0];
    seg_val = (!is_space && (char_code_i != aclwm_pkg::SepCode)) ? sum_sat : sum_q;
    do_close = (!is_space && (char_code_i == aclwm_pkg::SepCode)) ||
               (last_char_i && (seg_val != '0));
    seen_n = seen_q || !is_space;
    if (!do_close) begin
      idx_n = idx_q;
    end else if (idx_q < MaxSeg) begin
      idx_n = idx_q + 1'b1;
    end else begin
      idx_n = TooMany;
    end
    if (!seen_n) begin
      rule_status = aclwm_pkg::StRuleEmpty;
    end else if (idx_n > MaxSeg) begin
      rule_status = aclwm_pkg::StRuleTooLong;
    end else if (total >= MaxR) begin
      rule_status = aclwm_pkg::StTableFull;
    end else begin
      rule_status = aclwm_pkg::StRuleStored;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && do_close && (idx_q < MaxSeg)) begin
      build_q[idx_q[SW-1:0]] <= seg_val;
    end
  end

  // Search order: deny rules fill slots downward from the top (newest first),
  // allow rules fill slots upward from zero.
  assign walk_slot = ({1'b0, pos_q} < deny_cnt_q) ? (MaxR - deny_cnt_q + {1'b0, pos_q})
                                                  : ({1'b0, pos_q} - deny_cnt_q);

  assign n_seg     = cnt_rdata[CW-1:0];
  assign seg_i_inc = seg_i_q + 1'b1;
  assign seg_last  = ({1'b0, seg_i_q} + 1'b1) == {1'b0, n_seg};
  assign seg_ok    = (seg_rdata == AnyV) || ((seg_rdata == OwnerV) && eq_q) ||
                     ((seg_rdata != OwnerV) && (seg_rdata == build_q[seg_i_q[SW-1:0]]));
  assign do_store  = !req_type_i && (rule_status == aclwm_pkg::StRuleStored);

  always_comb begin
    state_d = state_q;
    sum_d = sum_q;
    idx_d = idx_q;
    seen_d = seen_q;
    allow_cnt_d = allow_cnt_q;
    deny_cnt_d = deny_cnt_q;
    qcnt_d = qcnt_q;
    eq_d = eq_q;
    pos_d = pos_q;
    slot_d = slot_q;
    seg_i_d = seg_i_q;
    res_allow_d = res_allow_q;
    res_hit_d = res_hit_q;
    out_load = 1'b0;
    load_status = aclwm_pkg::StQueryDone;
    load_grant = 1'b0;
    load_hit = 1'b0;
    load_pos = '0;
    cnt_we = 1'b0;
    cnt_waddr = slot_q;
    cnt_wdata = {rule_allows_i, idx_n[CW-1:0]};
    cnt_re = 1'b0;
    cnt_raddr = walk_slot[RW-1:0];
    seg_we = 1'b0;
    seg_waddr = {slot_q, seg_i_q[SW-1:0]};
    seg_re = 1'b0;
    seg_raddr = {walk_slot[RW-1:0], SW'(0)};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          seen_d = seen_n;
          idx_d = idx_n;
          if (!is_space && (char_code_i != aclwm_pkg::SepCode)) begin
            sum_d = sum_sat;
          end else if (do_close) begin
            sum_d = '0;
          end
          if (last_char_i) begin
            sum_d = '0;
            idx_d = '0;
            seen_d = 1'b0;
            if (req_type_i) begin
              qcnt_d = idx_n;
              eq_d = (user_id_i == owner_id_i);
              pos_d = '0;
              res_hit_d = 1'b0;
              res_allow_d = 1'b0;
              state_d = (total == '0) ? S_RES : S_RCNT;
            end else begin
              out_load = 1'b1;
              load_status = rule_status;
              if (do_store) begin
                slot_d = rule_allows_i ? allow_cnt_q[RW-1:0] : deny_slot[RW-1:0];
                cnt_we = 1'b1;
                cnt_waddr = slot_d;
                if (rule_allows_i) begin
                  allow_cnt_d = allow_cnt_q + 1'b1;
                end else begin
                  deny_cnt_d = deny_cnt_q + 1'b1;
                end
                qcnt_d = idx_n;
                seg_i_d = '0;
                if (idx_n != '0) begin
                  state_d = S_WRITE;
                end
              end
            end
          end
        end
      end
      S_WRITE: begin
        seg_we = 1'b1;
        seg_i_d = seg_i_inc;
        if (IW'(seg_i_inc) == qcnt_q) begin
          state_d = S_IDLE;
        end
      end
      S_RCNT: begin
        cnt_re = 1'b1;
        seg_re = 1'b1;
        slot_d = walk_slot[RW-1:0];
        seg_i_d = '0;
        state_d = S_SEG;
      end
      S_SEG: begin
        if (seg_i_q == n_seg) begin
          res_hit_d = (IW'(n_seg) == qcnt_q);
        end else if (IW'(seg_i_q) == qcnt_q) begin
          res_hit_d = 1'b0;
        end else if ((seg_rdata == AnyV) && seg_last) begin
          res_hit_d = 1'b1;
        end else begin
          res_hit_d = 1'b0;
        end
        res_allow_d = cnt_rdata[CW];
        if ((seg_i_q != n_seg) && (IW'(seg_i_q) != qcnt_q) &&
            !((seg_rdata == AnyV) && seg_last) && seg_ok) begin
          // segment matched, keep comparing
          seg_i_d = seg_i_inc;
          seg_re = 1'b1;
          seg_raddr = {slot_q, seg_i_inc[SW-1:0]};
        end else if (res_hit_d || (({1'b0, pos_q} + 1'b1) == total)) begin
          state_d = S_RES;
        end else begin
          pos_d = pos_q + 1'b1;
          state_d = S_RCNT;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_load = 1'b1;
          load_status = aclwm_pkg::StQueryDone;
          load_hit = res_hit_q;
          load_grant = res_hit_q && res_allow_q;
          load_pos = res_hit_q ? aclwm_pkg::PosWidth'(pos_q) : '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sum_q <= '0;
      idx_q <= '0;
      seen_q <= 1'b0;
      allow_cnt_q <= '0;
      deny_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q <= sum_d;
      idx_q <= idx_d;
      seen_q <= seen_d;
      allow_cnt_q <= allow_cnt_d;
      deny_cnt_q <= deny_cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qcnt_q <= qcnt_d;
    eq_q <= eq_d;
    pos_q <= pos_d;
    slot_q <= slot_d;
    seg_i_q <= seg_i_d;
    res_allow_q <= res_allow_d;
    res_hit_q <= res_hit_d;
    if (out_load) begin
      status_q <= load_status;
      grant_q <= load_grant;
      hit_q <= load_hit;
      mpos_q <= load_pos;
    end
  end

  aclwm_ram #(
    .WIDTH(CW + 1),
    .DEPTH(MAX_RULES)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .re_i   (cnt_re),
    .raddr_i(cnt_raddr),
    .rdata_o(cnt_rdata)
  );

  aclwm_ram #(
    .WIDTH(SEGMENT_WIDTH),
    .DEPTH(MAX_RULES << SW)
  ) u_seg_ram (
    .clk_i  (clk_i),
    .we_i   (seg_we),
    .waddr_i(seg_waddr),
    .wdata_i(build_q[seg_i_q[SW-1:0]]),
    .re_i   (seg_re),
    .raddr_i(seg_raddr),
    .rdata_o(seg_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign access_granted_o = grant_q;
  assign rule_matched_o   = hit_q;
  assign match_position_o = mpos_q;

endmodule
